// ===== design/command_frame_parser_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command frame parser queue
// Concurrent assertion shorthands used by the port monitor.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_PARSER_QUEUE_ASSERT_SVH
`define COMMAND_FRAME_PARSER_QUEUE_ASSERT_SVH

// same-cycle implication, off during reset
`define CFPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CFPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches the reset itself
`define CFPQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cfpq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpq_pkg
// Shared types, codes and character constants of the command frame parser.
// ----------------------------------------------------------------------------
package cfpq_pkg;

    localparam int CFPQ_FRAME_DEPTH = 16;
    localparam int CFPQ_QUEUE_DEPTH = 8;

    // op queue between front and back
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_PW    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

    // item selector
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic       KIND_MODE   = 1'b0;
    localparam logic       KIND_MOTION = 1'b1;

    localparam logic [1:0] MODE_I = 2'd0;
    localparam logic [1:0] MODE_U = 2'd1;
    localparam logic [1:0] MODE_L = 2'd2;
    localparam logic [1:0] MODE_F = 2'd3;

    localparam logic [2:0] DIR_STOP = 3'd4;

    typedef enum logic [3:0] {
        OC_IGNORED  = 4'd0,
        OC_STORED   = 4'd1,
        OC_START    = 4'd2,
        OC_OVERFLOW = 4'd3,
        OC_QUEUED   = 4'd4,
        OC_FULL     = 4'd5,
        OC_INVALID  = 4'd6,
        OC_POPPED   = 4'd7,
        OC_EMPTY    = 4'd8,
        OC_CLEARED  = 4'd9
    } t_outcome;

    typedef enum logic [1:0] {
        OP_RESULT,
        OP_PUSH,
        OP_POP
    } t_op_kind;

    typedef struct packed {
        logic [3:0] speed;
        logic [2:0] direction;
        logic [1:0] mode;
        logic       kind;
    } t_cmd;

    // classified item handed from front to back
    typedef struct packed {
        t_op_kind kind;
        t_outcome outcome;
        t_cmd     word;
    } t_op;

endpackage

// ===== design/cfpq_front.sv =====
// ----------------------------------------------------------------------------
// cfpq_front
// Frame assembly and command decode; emits one classified op per item.
// ----------------------------------------------------------------------------
module cfpq_front
    import cfpq_pkg::*;
#(
    parameter int FRAME_DEPTH = CFPQ_FRAME_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_op_push,
    output t_op        o_op,
    input  logic       i_op_full
);

    localparam int LW = $clog2(FRAME_DEPTH);

    typedef struct packed {
        logic ok;
        t_cmd cmd;
    } t_frame_check;

    logic [LW-1:0]   r_len;
    logic [LW-1:0]   n_len;
    logic [4:0][7:0] r_chars;
    logic            accept;
    logic            store_char;
    t_op             op;
    t_frame_check    chk;

    function automatic t_frame_check check_frame(input logic is5, input logic is7,
                                                 input logic [4:0][7:0] f);
        t_frame_check res;
        logic         plain;
        logic         stop_form;
        res       = '0;
        plain     = (f[0] == CH_D) && (f[1] == CH_COLON) && (f[3] == CH_COMMA);
        stop_form = (f[0] == CH_D) && (f[1] == CH_COMMA) && (f[2] == CH_5) &&
                    (f[3] == CH_COMMA);
        if (is5) begin
            if ((f[0] == CH_M) && (f[1] == CH_COLON)) begin
                res.cmd.kind = KIND_MODE;
                case (f[2])
                    CH_I: begin res.ok = 1'b1; res.cmd.mode = MODE_I; end
                    CH_U: begin res.ok = 1'b1; res.cmd.mode = MODE_U; end
                    CH_L: begin res.ok = 1'b1; res.cmd.mode = MODE_L; end
                    CH_F: begin res.ok = 1'b1; res.cmd.mode = MODE_F; end
                    default: res.ok = 1'b0;
                endcase
            end
        end else if (is7) begin
            if ((plain || stop_form) && (f[4] inside {[CH_0:CH_9]})) begin
                res.cmd.kind  = KIND_MOTION;
                res.cmd.speed = 4'(f[4] - CH_0);
                if (f[2] inside {[CH_1:CH_4]}) begin
                    res.ok            = plain;
                    res.cmd.direction = 3'(f[2] - CH_1);
                end else if (f[2] == CH_5) begin
                    res.ok            = 1'b1;
                    res.cmd.direction = DIR_STOP;
                end
            end
        end
        if (!res.ok) begin
            res.cmd = '0;
        end
        return res;
    endfunction

    assign accept     = i_in_valid && !i_op_full;
    assign o_in_stall = i_op_full;
    assign o_op_push  = accept;
    assign o_op       = op;

    // positions 1..3 (length 5) or 1..5 (length 7) are written before the ';'
    assign chk = check_frame(r_len == LW'(4), r_len == LW'(6), r_chars);

    always_comb begin
        n_len      = r_len;
        store_char = 1'b0;
        op         = '0;
        op.kind    = OP_RESULT;
        op.outcome = OC_IGNORED;
        case (i_cmd)
            CMD_BYTE: begin
                if (i_rx_byte == CH_HASH) begin
                    n_len      = LW'(1);
                    op.outcome = OC_START;
                end else if (r_len == '0) begin
                    op.outcome = OC_IGNORED;
                end else if (r_len >= LW'(FRAME_DEPTH - 1)) begin
                    n_len      = '0;
                    op.outcome = OC_OVERFLOW;
                end else begin
                    store_char = 1'b1;
                    n_len      = r_len + 1'b1;
                    op.outcome = OC_STORED;
                    if (i_rx_byte == CH_SEMI) begin
                        n_len = '0;
                        if (chk.ok) begin
                            op.kind    = OP_PUSH;
                            op.outcome = OC_QUEUED;
                            op.word    = chk.cmd;
                        end else begin
                            op.outcome = OC_INVALID;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                n_len      = '0;
                op.outcome = OC_CLEARED;
            end
            CMD_POP: begin
                op.kind    = OP_POP;
                op.outcome = OC_POPPED;
            end
            default: op.outcome = OC_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (accept) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 5; k++) begin
            if (accept && store_char && (r_len == LW'(k + 1))) begin
                r_chars[k] <= i_rx_byte;
            end
        end
    end

endmodule

// ===== design/cfpq_op_fifo.sv =====
// ----------------------------------------------------------------------------
// cfpq_op_fifo
// Short queue of classified ops between the parser and the command queue.
// ----------------------------------------------------------------------------
module cfpq_op_fifo
    import cfpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_PW-1:0] r_wr;
    logic [OPQ_PW-1:0] r_rd;
    logic [OPQ_CW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == OPQ_CW'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == OPQ_PW'(OPQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// ===== design/cfpq_back.sv =====
// ----------------------------------------------------------------------------
// cfpq_back
// Command ring queue; executes push/pop ops and holds the result register.
// ----------------------------------------------------------------------------
module cfpq_back
    import cfpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFPQ_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_empty,
    input  t_op        i_op,
    output logic       o_op_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_outcome,
    output logic       o_cmd_kind,
    output logic [1:0] o_detect_mode,
    output logic [2:0] o_direction,
    output logic [3:0] o_speed,
    output logic [3:0] o_queue_fill
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_queue [QUEUE_DEPTH];
    logic [QPW-1:0] r_head;
    logic [QPW-1:0] r_tail;
    logic [CW-1:0]  r_count;
    logic           r_out_valid;
    t_outcome       r_outcome;
    t_cmd           r_word;

    logic           take;
    logic           do_push;
    logic           do_pop;
    t_outcome       n_outcome;
    logic [8:0]     fill_ext;

    assign take     = !i_op_empty && (!r_out_valid || !i_out_stall);
    assign o_op_pop = take;

    always_comb begin
        do_push   = 1'b0;
        do_pop    = 1'b0;
        n_outcome = i_op.outcome;
        case (i_op.kind)
            OP_PUSH: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_outcome = OC_FULL;
                end else begin
                    do_push   = take;
                    n_outcome = OC_QUEUED;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_outcome = OC_EMPTY;
                end else begin
                    do_pop    = take;
                    n_outcome = OC_POPPED;
                end
            end
            default: n_outcome = i_op.outcome;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= take;
            end
            if (do_push) begin
                r_tail  <= (r_tail == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (do_pop) begin
                r_head  <= (r_head == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue store and result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_outcome <= n_outcome;
            r_word    <= '0;
            if (do_pop) begin
                r_word <= r_queue[r_head];
            end
            if (do_push) begin
                r_queue[r_tail] <= i_op.word;
            end
        end
    end

    // the fill count only moves when a new result is loaded
    assign fill_ext      = 9'(r_count);
    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_cmd_kind    = r_word.kind;
    assign o_detect_mode = r_word.mode;
    assign o_direction   = r_word.direction;
    assign o_speed       = r_word.speed;
    assign o_queue_fill  = fill_ext[3:0];

endmodule

// ===== design/command_frame_parser_queue.sv =====
// ----------------------------------------------------------------------------
// command_frame_parser_queue
// Serial command frame parser feeding a ring queue of decoded commands.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// i_cmd selects a received byte (i_rx_byte), a line error or a pop request.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item, in order: outcome code, popped command fields and queue fill.
// Throughput is one item per cycle while the output is not stalled; the
// front parser and the back queue have no busy state of their own.
// From input accept to result valid, the parser writes its op into the
// op queue when the item is accepted, and the queue stage then loads the
// result register, which feeds the output directly, from the op queue.
// A 2-entry op queue sits between parser and command queue. When the
// receiver stalls, the result register holds, the op queue fills, and
// o_in_stall rises once it holds two ops; it falls as soon as one drains.
// Reset (synchronous, active low) closes any open frame, empties the
// command queue and the op queue, and drops any pending result.
// ----------------------------------------------------------------------------
module command_frame_parser_queue
    import cfpq_pkg::*;
#(
    parameter int FRAME_DEPTH = CFPQ_FRAME_DEPTH,
    parameter int QUEUE_DEPTH = CFPQ_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_outcome,
    output logic       o_cmd_kind,
    output logic [1:0] o_detect_mode,
    output logic [2:0] o_direction,
    output logic [3:0] o_speed,
    output logic [3:0] o_queue_fill
);

    logic op_push;
    t_op  op_in;
    logic op_full;
    logic op_pop;
    t_op  op_out;
    logic op_empty;

    cfpq_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .o_op_push  (op_push),
        .o_op       (op_in),
        .i_op_full  (op_full)
    );

    cfpq_op_fifo u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_op    (op_out),
        .o_empty (op_empty)
    );

    cfpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_empty    (op_empty),
        .i_op          (op_out),
        .o_op_pop      (op_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_outcome     (o_outcome),
        .o_cmd_kind    (o_cmd_kind),
        .o_detect_mode (o_detect_mode),
        .o_direction   (o_direction),
        .o_speed       (o_speed),
        .o_queue_fill  (o_queue_fill)
    );

endmodule

// ===== design/cfpq_port_monitor.sv =====
// ----------------------------------------------------------------------------
// cfpq_port_monitor
// Port-level checks on the command frame parser queue, bound to the top.
// ----------------------------------------------------------------------------
`include "command_frame_parser_queue_assert.svh"

module cfpq_port_monitor
    import cfpq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [3:0] o_outcome,
    input logic       o_cmd_kind,
    input logic [1:0] o_detect_mode,
    input logic [2:0] o_direction,
    input logic [3:0] o_speed
);

    `CFPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // only popped results carry command fields
    `CFPQ_ASSERT_SAME(a_fields_zero, i_clk, i_rst_n, o_out_valid && (o_outcome != OC_POPPED), (o_cmd_kind == 1'b0) && (o_detect_mode == 2'd0) && (o_direction == 3'd0) && (o_speed == 4'd0), "command fields set on non-pop result")

    // a popped mode command has no motion part and vice versa
    `CFPQ_ASSERT_SAME(a_pop_shape, i_clk, i_rst_n, o_out_valid && (o_outcome == OC_POPPED), (o_cmd_kind == KIND_MOTION) ? (o_detect_mode == 2'd0) : ((o_direction == 3'd0) && (o_speed == 4'd0)), "popped command fields inconsistent")

    `CFPQ_ASSERT_NEXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, !o_in_stall && !o_out_valid, "not idle after reset")

endmodule

bind command_frame_parser_queue cfpq_port_monitor u_port_monitor (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_outcome     (o_outcome),
    .o_cmd_kind    (o_cmd_kind),
    .o_detect_mode (o_detect_mode),
    .o_direction   (o_direction),
    .o_speed       (o_speed)
);
